// ===== hw/rtl/fca_pkg.sv =====
// Shared types and constants for the FIFO-replacement associative cache.
package fca_pkg;

	localparam int CAP_W          = 5;
	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;
	localparam int OP_W           = 2;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_GET   = 2'd0,
		OP_PUT   = 2'd1,
		OP_INVAL = 2'd2
	} fca_op_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_CMP  = 6'b000100,
		ST_RES  = 6'b001000,
		ST_VAL  = 6'b010000,
		ST_OUT  = 6'b100000
	} fca_state_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} fca_res_t;

endpackage

// ===== hw/rtl/fca_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/fca_ctrl.sv =====
// Sequencer: walks the key RAM through one shared key compare, then applies the operation.
module fca_ctrl
	import fca_pkg::*;
#(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int KEY_BITS   = DEF_KEY_BITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CAP_W-1:0]      cap,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  fca_op_t               req_op,
	input  logic [KEY_BITS-1:0]   req_key,
	input  logic [VALUE_BITS-1:0] req_value,
	output fca_res_t              res,
	input  logic                  res_ready,
	output logic [VALUE_BITS-1:0] res_value
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	fca_state_t            state_q;
	fca_op_t               op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] wval_q;
	logic [CNT_W-1:0]      scan_q;
	logic [IDX_W-1:0]      match_q;
	logic [IDX_W-1:0]      free_q;
	logic                  found_q;
	logic                  free_ok_q;
	logic [ENTRIES-1:0]    valid_q;
	logic [CNT_W-1:0]      fill_q;
	logic [IDX_W-1:0]      oldest_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] rval_q;

	logic [CW-1:0]         cap_x;
	logic [CNT_W-1:0]      eff_cap;
	logic [IDX_W-1:0]      scan_idx;
	logic                  cmp_valid;
	logic                  cmp_hit;
	logic                  scan_end;
	logic [IDX_W-1:0]      ptr_p;
	logic [CNT_W-1:0]      ptr_inc;
	logic [IDX_W-1:0]      ptr_nx;
	logic                  use_free;
	logic [IDX_W-1:0]      ins_slot;
	logic                  op_known;

	logic                  key_we;
	logic                  val_we;
	logic [IDX_W-1:0]      wr_addr;
	logic [KEY_BITS-1:0]   key_rdata;
	logic [VALUE_BITS-1:0] val_rdata;

	// Clamp the capacity register into 1..ENTRIES.
	always_comb begin
		cap_x = CW'(cap);
		if (cap_x == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_x > CW'(ENTRIES)) begin
			eff_cap = CNT_W'(ENTRIES);
		end else begin
			eff_cap = CNT_W'(cap_x);
		end
	end

	assign scan_idx  = scan_q[IDX_W-1:0];
	assign cmp_valid = valid_q[scan_idx];
	assign cmp_hit   = cmp_valid && (key_rdata == key_q);
	assign scan_end  = (scan_q >= eff_cap);

	// Out-of-range pointer evicts slot 0.
	assign ptr_p    = (CNT_W'(oldest_q) < eff_cap) ? oldest_q : '0;
	assign ptr_inc  = CNT_W'(ptr_p) + CNT_W'(1);
	assign ptr_nx   = (ptr_inc >= eff_cap) ? '0 : ptr_inc[IDX_W-1:0];
	assign use_free = free_ok_q && (fill_q < eff_cap);
	assign ins_slot = use_free ? free_q : ptr_p;
	assign op_known = (op_q == OP_GET) || (op_q == OP_PUT) || (op_q == OP_INVAL);

	always_comb begin
		key_we  = 1'b0;
		val_we  = 1'b0;
		wr_addr = match_q;
		if (state_q == ST_RES && op_q == OP_PUT) begin
			if (found_q) begin
				val_we = 1'b1;
			end else begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				wr_addr = ins_slot;
			end
		end
	end

	fca_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (wr_addr),
		.wdata (key_q),
		.raddr (scan_idx),
		.rdata (key_rdata)
	);

	fca_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (wr_addr),
		.wdata (wval_q),
		.raddr (match_q),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			scan_q    <= '0;
			found_q   <= 1'b0;
			free_ok_q <= 1'b0;
			valid_q   <= '0;
			fill_q    <= '0;
			oldest_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q   <= ST_RD;
						scan_q    <= '0;
						found_q   <= 1'b0;
						free_ok_q <= 1'b0;
					end
				end
				ST_RD: begin
					state_q <= scan_end ? ST_RES : ST_CMP;
				end
				ST_CMP: begin
					if (cmp_hit) begin
						found_q <= 1'b1;
						state_q <= ST_RES;
					end else begin
						if (!cmp_valid) begin
							free_ok_q <= 1'b1;
						end
						scan_q  <= scan_q + CNT_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_RES: begin
					case (op_q)
						OP_PUT: begin
							if (!found_q) begin
								valid_q[ins_slot] <= 1'b1;
								if (use_free) begin
									fill_q <= fill_q + CNT_W'(1);
								end else begin
									oldest_q <= ptr_nx;
								end
							end
						end
						OP_INVAL: begin
							if (found_q) begin
								valid_q[match_q] <= 1'b0;
								if (fill_q != '0) begin
									fill_q <= fill_q - CNT_W'(1);
								end
							end
						end
						default: begin
						end
					endcase
					state_q <= (op_q == OP_GET && found_q) ? ST_VAL : ST_OUT;
				end
				ST_VAL: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					op_q   <= req_op;
					key_q  <= req_key;
					wval_q <= req_value;
				end
			end
			ST_CMP: begin
				if (cmp_hit) begin
					match_q <= scan_idx;
				end
				// Keep the lowest free slot seen.
				if (!cmp_valid && !free_ok_q) begin
					free_q <= scan_idx;
				end
			end
			ST_RES: begin
				hit_q  <= found_q && op_known;
				rval_q <= '0;
			end
			ST_VAL: begin
				rval_q <= val_rdata;
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_OUT);
	assign res.hit   = hit_q;
	assign res_value = rval_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("fill count above store depth");

	// The capacity may drop while idle, so only check during an operation.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (scan_q <= eff_cap))
		else $error("scan index past capacity");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_RD && scan_q == '0))
		else $error("accepted beat did not start a scan");

	a_hit_stops_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && cmp_hit) |=> (state_q == ST_RES && found_q))
		else $error("key match did not end the scan");

	a_fill_moves_in_res: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> ($past(state_q) == ST_RES))
		else $error("fill count changed outside resolve step");
`endif

endmodule

// ===== hw/rtl/fifo_replacement_assoc_cache_core.sv =====
// Flow: after accept, the scan alternates a key RAM read (ST_RD) and a compare (ST_CMP) for
// each slot up to the capacity, stopping at the first match, then resolves the operation
// (ST_RES); a get hit adds a value RAM read (ST_VAL) before the result (ST_OUT). A new beat
// is accepted only after the previous result has moved on to the output register.
// Reset: arst_n clears valid bits, fill count, oldest pointer and sequencer; capacity
// returns to 16; key and value RAM contents are left as they are.
module fifo_replacement_assoc_cache_core
	import fca_pkg::*;
#(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int KEY_BITS   = DEF_KEY_BITS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_tvalid,
	output logic                                       s_tready,
	// key, write_value
	input  logic [((KEY_BITS + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// opcode
	input  logic [OP_W-1:0]                            s_tuser,
	output logic                                       m_tvalid,
	input  logic                                       m_tready,
	// read_value
	output logic [((VALUE_BITS + 7) / 8) * 8 - 1:0]    m_tdata,
	// hit
	output logic                                       m_tuser,
	input  logic                                       cfg_we,
	input  logic [CAP_W-1:0]                           cfg_wdata
);

	logic [CAP_W-1:0]      cap_q;
	logic                  m_valid_q;
	logic                  m_hit_q;
	logic [VALUE_BITS-1:0] m_val_q;
	fca_res_t              res;
	logic [VALUE_BITS-1:0] res_value;
	logic                  res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	fca_ctrl #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_op    (fca_op_t'(s_tuser)),
		.req_key   (s_tdata[KEY_BITS-1:0]),
		.req_value (s_tdata[KEY_BITS +: VALUE_BITS]),
		.res       (res),
		.res_ready (res_ready),
		.res_value (res_value)
	);

	// Load the output register when it is empty or its beat leaves this cycle.
	assign res_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			m_hit_q <= res.hit;
			m_val_q <= res_value;
		end
	end

	always_comb begin
		m_tdata                   = '0;
		m_tdata[VALUE_BITS-1:0]   = m_val_q;
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_hit_q;

endmodule

// ===== tb/fifo_replacement_assoc_cache_core_test.sv =====
// Self-checking bench for the FIFO-replacement associative cache core.
`timescale 1ns / 100ps

typedef struct {
	bit          hit;
	logic [31:0] read_value;
} cache_reply_t;

class cache_mirror;
	bit           slot_valid [fca_pkg::DEF_ENTRIES];
	logic [31:0]  slot_key   [fca_pkg::DEF_ENTRIES];
	logic [31:0]  slot_value [fca_pkg::DEF_ENTRIES];
	int unsigned  fill_count;
	int unsigned  oldest_slot;
	logic [4:0]   capacity;
	cache_reply_t awaited_replies[$];
	int           failures;

	function new();
		foreach (slot_valid[i]) begin
			slot_valid[i] = 1'b0;
		end
		fill_count  = 0;
		oldest_slot = 0;
		capacity    = fca_pkg::CAP_RESET;
		failures    = 0;
	endfunction

	function void set_capacity(logic [4:0] value);
		capacity = value;
	endfunction

	function int unsigned slots_in_use();
		if (capacity == 0) begin
			return 1;
		end
		if (capacity > fca_pkg::DEF_ENTRIES) begin
			return fca_pkg::DEF_ENTRIES;
		end
		return capacity;
	endfunction

	function int pending();
		return awaited_replies.size();
	endfunction

	function void note_request(logic [1:0] op, logic [31:0] key, logic [31:0] write_value);
		int unsigned  used;
		int           match;
		int           slot;
		cache_reply_t reply;
		used             = slots_in_use();
		match            = -1;
		reply.hit        = 1'b0;
		reply.read_value = '0;
		for (int i = 0; i < used; i++) begin
			if (match < 0 && slot_valid[i] && slot_key[i] == key) begin
				match = i;
			end
		end
		case (op)
			fca_pkg::OP_GET: begin
				if (match >= 0) begin
					reply.hit        = 1'b1;
					reply.read_value = slot_value[match];
				end
			end
			fca_pkg::OP_PUT: begin
				if (match >= 0) begin
					reply.hit         = 1'b1;
					slot_value[match] = write_value;
				end else begin
					slot = -1;
					if (fill_count < used) begin
						for (int i = 0; i < used; i++) begin
							if (slot < 0 && !slot_valid[i]) begin
								slot = i;
							end
						end
						if (slot >= 0) begin
							fill_count++;
						end
					end
					// evict at the oldest slot, restarting at 0 if it fell outside capacity
					if (slot < 0) begin
						slot        = (oldest_slot < used) ? oldest_slot : 0;
						oldest_slot = (slot + 1 >= used) ? 0 : slot + 1;
					end
					slot_key[slot]   = key;
					slot_value[slot] = write_value;
					slot_valid[slot] = 1'b1;
				end
			end
			fca_pkg::OP_INVAL: begin
				if (match >= 0) begin
					reply.hit         = 1'b1;
					slot_valid[match] = 1'b0;
					if (fill_count > 0) begin
						fill_count--;
					end
				end
			end
			default: ;
		endcase
		awaited_replies.push_back(reply);
	endfunction

	function void check_reply(bit hit, logic [31:0] read_value);
		cache_reply_t want;
		if (awaited_replies.size() == 0) begin
			failures++;
			$display("%0t: result beat with none awaited: hit %0b read_value %08h",
				$time, hit, read_value);
			return;
		end
		want = awaited_replies.pop_front();
		if (hit !== want.hit) begin
			failures++;
			$display("%0t: hit mismatch: expected %0b actual %0b", $time, want.hit, hit);
		end
		if (read_value !== want.read_value) begin
			failures++;
			$display("%0t: read_value mismatch: expected %08h actual %08h",
				$time, want.read_value, read_value);
		end
	endfunction
endclass

module fifo_replacement_assoc_cache_core_test;
	import fca_pkg::*;

	localparam logic [OP_W-1:0] OP_NONE = 2'd3;
	localparam int              QUIET_LIMIT = 2000;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [63:0]       s_tdata   = '0;
	logic [OP_W-1:0]   s_tuser   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;
	logic              m_tuser;
	logic              cfg_we    = 1'b0;
	logic [CAP_W-1:0]  cfg_wdata = '0;

	cache_mirror       mirror = new();
	bit                bursty = 1'b1;
	int                ready_hold = 0;
	int                quiet_cycles = 0;
	logic [31:0]       key_pool[$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	fifo_replacement_assoc_cache_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// result side: random stall bursts, check every accepted beat
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mirror.check_reply(m_tuser, m_tdata);
		end
		if (ready_hold > 0) begin
			ready_hold--;
			m_tready <= 1'b0;
		end else if (bursty && $urandom_range(0, 4) == 0) begin
			ready_hold = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// leaves tvalid high after the accepting edge; drain_replies drops it
	task automatic issue_request(logic [OP_W-1:0] op, logic [31:0] key, logic [31:0] wval);
		if (bursty && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {wval, key};
		do @(posedge clk); while (!s_tready);
		mirror.note_request(op, key, wval);
	endtask

	task automatic drain_replies();
		s_tvalid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		drain_replies();
		while (!s_tready) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_capacity(value);
	endtask

	// pool a little larger than the live slots, so hits and evictions both happen
	task automatic random_traffic(logic [CAP_W-1:0] value, int beats);
		int          used;
		int          pick;
		logic [1:0]  op;
		logic [31:0] key;
		logic [31:0] wval;
		write_capacity(value);
		used = (value == 0) ? 1 : (value > DEF_ENTRIES) ? DEF_ENTRIES : value;
		key_pool.delete();
		repeat (used + $urandom_range(1, 6)) begin
			pick = $urandom_range(0, 9);
			key_pool.push_back(pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF : $urandom);
		end
		repeat (beats) begin
			pick = $urandom_range(0, 99);
			op   = pick < 40 ? OP_GET : pick < 80 ? OP_PUT : pick < 95 ? OP_INVAL : OP_NONE;
			key  = ($urandom_range(0, 9) == 0) ? $urandom
				: key_pool[$urandom_range(0, key_pool.size() - 1)];
			pick = $urandom_range(0, 15);
			wval = pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF_FFFF : $urandom;
			issue_request(op, key, wval);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(5'd16);
		issue_request(OP_GET,   32'h0000_0000, 32'hA5A5_A5A5);
		issue_request(OP_PUT,   32'h0000_0000, 32'hFFFF_FFFF);
		issue_request(OP_PUT,   32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(OP_GET,   32'h0000_0000, 32'h0000_0000);
		issue_request(OP_PUT,   32'h0000_0000, 32'h1234_5678);
		issue_request(OP_GET,   32'h0000_0000, 32'hFFFF_FFFF);
		issue_request(OP_INVAL, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(OP_INVAL, 32'hFFFF_FFFF, 32'h0000_0000);
		issue_request(OP_NONE,  32'h0000_0000, 32'hFFFF_FFFF);
		// fill the free slots, then evict the oldest entry
		for (int i = 1; i <= 16; i++) begin
			issue_request(OP_PUT, 32'h8000_0000 | i, $urandom);
		end
		issue_request(OP_GET,   32'h0000_0000, 32'h0000_0000);

		random_traffic(5'd16, 90);
		random_traffic(5'd3, 50);
		random_traffic(5'd0, 35);
		random_traffic(5'd1, 35);
		random_traffic(5'd31, 60);
		random_traffic(CAP_W'($urandom_range(2, 15)), 60);
		random_traffic(CAP_W'($urandom_range(17, 30)), 40);
		bursty = 1'b0;
		random_traffic(5'd16, 70);

		drain_replies();
		repeat (40) @(posedge clk);
		if (mirror.failures == 0 && mirror.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
